/* sv/stepped_sine_sweep_telemetry_defines.svh */
// Assertion macros shared by the stepped sine sweep telemetry RTL.
`ifndef STEPPED_SINE_SWEEP_TELEMETRY_DEFINES_SVH
`define STEPPED_SINE_SWEEP_TELEMETRY_DEFINES_SVH

// Same-cycle implication, sampled on clk and disabled while arst_n is low.
`define SST_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk and disabled while arst_n is low.
`define SST_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* sv/sst_pkg.sv */
// Package with the constants, types and tables of the stepped sine sweep block.
`timescale 1ns / 1ps
package sst_pkg;

	// Sweep and frame constants.
	localparam int FREQ_STEPS  = 10;
	localparam int PHASE_MOD   = 1000;
	localparam int QUARTER     = 250;
	localparam int FRAME_LEN   = 11;
	localparam int IDX_W       = $clog2(FRAME_LEN);
	localparam logic [7:0] HDR0 = 8'h5A;
	localparam logic [7:0] HDR1 = 8'hA5;

	// Reciprocal of 1000 in Q20, rounded down so the quotient is low by at most one.
	localparam int RECIP_1000  = 1048;
	localparam int RECIP_SHIFT = 20;

	// Q1.15 full scale and the rounding offset of the amplitude scaling.
	localparam int AMP_FULL    = 32767;
	localparam int ROUND_HALF  = 16383;

	// Configuration register reset values and indexes.
	localparam logic [15:0] DWELL_RESET = 16'd1000;
	localparam logic [14:0] AMP_RESET   = 15'd32767;
	localparam int          ADDR_W      = 3;
	localparam logic [0:0]  REG_DWELL   = 1'b0;
	localparam logic [0:0]  REG_AMP     = 1'b1;

	// Depth of the queue between the front and the back.
	localparam int QDEPTH  = 4;
	localparam int QPTR_W  = $clog2(QDEPTH);
	localparam int QCNT_W  = $clog2(QDEPTH + 1);

	// Sweep frequencies in Hz; entries past the tenth hold the last one.
	typedef logic [7:0] sweep_table_t [16];
	localparam sweep_table_t SWEEP_TABLE = '{
		8'd1, 8'd5, 8'd10, 8'd20, 8'd30, 8'd40, 8'd50, 8'd80,
		8'd100, 8'd150, 8'd150, 8'd150, 8'd150, 8'd150, 8'd150, 8'd150
	};

	// Taylor coefficients of the sine in Q30.
	localparam logic [63:0] C1 = 64'd1686629713;
	localparam logic [63:0] C3 = 64'd693598668;
	localparam logic [63:0] C5 = 64'd85569306;
	localparam logic [63:0] C7 = 64'd5026995;
	localparam logic [63:0] C9 = 64'd172272;

	typedef logic [14:0] sine_rom_t [256];

	// Quarter-wave table in Q1.15, evaluated once at elaboration.
	function automatic sine_rom_t build_sine_rom();
		sine_rom_t   rom;
		logic [63:0] z;
		logic [63:0] z2;
		logic [63:0] p;
		logic [63:0] s;
		logic [63:0] v;
		logic [63:0] kk;
		for (int k = 0; k < 256; k++) begin
			kk = (k > QUARTER) ? 64'(QUARTER) : 64'(k);
			z  = (kk << 30) / QUARTER;
			z2 = (z * z) >> 30;
			p  = C9;
			p  = C7 - ((p * z2) >> 30);
			p  = C5 - ((p * z2) >> 30);
			p  = C3 - ((p * z2) >> 30);
			p  = C1 - ((p * z2) >> 30);
			s  = (p * z) >> 30;
			v  = (s * 64'd32767 + (64'd1 << 29)) >> 30;
			if (v > 64'd32767) begin
				v = 64'd32767;
			end
			rom[k] = v[14:0];
		end
		return rom;
	endfunction

	localparam sine_rom_t SINE_ROM = build_sine_rom();

	// Per-tick fields that ride along with the drive computation.
	typedef struct packed {
		logic [15:0] tick;
		logic [15:0] angle;
		logic [15:0] speed;
		logic [7:0]  freq;
	} sst_meta_t;

	// One queued tick: the finished drive value and the frame fields.
	typedef struct packed {
		logic signed [15:0] drive;
		sst_meta_t          meta;
	} sst_word_t;

	// Queue status seen by the front and the back.
	typedef struct packed {
		logic full;
		logic nonempty;
	} sst_qstat_t;

endpackage

/* sv/sst_if.sv */
// Handshake interfaces for the tick input channel and the telemetry output channel.
`timescale 1ns / 1ps
interface sst_in_if;
	logic               valid;
	logic               ready;
	logic [15:0]        rotor_angle;
	logic signed [15:0] measured_speed;

	modport source (output valid, rotor_angle, measured_speed, input ready);
	modport sink (input valid, rotor_angle, measured_speed, output ready);
endinterface

interface sst_out_if;
	logic               valid;
	logic               ready;
	logic signed [15:0] drive_value;
	logic [7:0]         frame_byte;
	logic               last_byte;

	modport source (output valid, drive_value, frame_byte, last_byte, input ready);
	modport sink (input valid, drive_value, frame_byte, last_byte, output ready);
endinterface

/* sv/sst_front.sv */
// Front: accepts ticks, steps the sweep state and computes the drive in a pipeline.
`timescale 1ns / 1ps
module sst_front (
	input  logic               clk,
	input  logic               arst_n,
	sst_in_if.sink             tick,
	input  logic [15:0]        dwell_ticks,
	input  logic [14:0]        amplitude,
	input  sst_pkg::sst_qstat_t q_stat,
	output logic               push,
	output sst_pkg::sst_word_t push_word
);
	import sst_pkg::*;

	localparam logic [9:0]  PHASE_LAST = 10'(PHASE_MOD - 1);
	localparam logic [4:0]  STEPS_W    = 5'(FREQ_STEPS);

	// Sweep state.
	logic [15:0] tick_low_q;
	logic [9:0]  phase_step_q;
	logic [15:0] dwell_count_q;
	logic [3:0]  freq_index_q;
	logic [7:0]  active_freq_q;

	// Stage valid bits.
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8;

	// Stage payloads.
	sst_meta_t meta_s1, meta_s2, meta_s3, meta_s4, meta_s5, meta_s6, meta_s7, meta_s8;
	logic [7:0]         old_freq_s1;
	logic [9:0]         ps_s1;
	logic [17:0]        prod_s2;
	logic [17:0]        prod_s3;
	logic [7:0]         qest_s3;
	logic [9:0]         phase_s4;
	logic [14:0]        entry_s5;
	logic               neg_s5, neg_s6, neg_s7;
	logic [29:0]        x_s6;
	logic [29:0]        x_s7;
	logic [15:0]        qd_s7;
	logic signed [15:0] drive_s8;

	// Front-end control and sweep-state next values.
	logic        en;
	logic        acc;
	logic [15:0] tick_nxt;
	logic [9:0]  ps_nxt;
	logic [16:0] dwell_inc;
	logic        step;
	logic [3:0]  fi_inc;
	logic [3:0]  fi_wrap;
	logic [3:0]  fi_new;
	logic [7:0]  freq_new;

	// The whole pipeline moves unless the last stage is held by a full queue.
	always_comb begin
		en        = !v_s8 || !q_stat.full;
		acc       = tick.valid && en;
		tick_nxt  = tick_low_q + 16'd1;
		ps_nxt    = (phase_step_q == PHASE_LAST) ? 10'd0 : phase_step_q + 10'd1;
		dwell_inc = {1'b0, dwell_count_q} + 17'd1;
		step      = dwell_inc >= {1'b0, dwell_ticks};
		fi_inc    = freq_index_q + 4'd1;
		fi_wrap   = ({1'b0, fi_inc} >= STEPS_W) ? 4'd0 : fi_inc;
		fi_new    = step ? fi_wrap : freq_index_q;
		freq_new  = SWEEP_TABLE[fi_new];
	end

	assign tick.ready = en;

	// Sweep state advances once per accepted tick.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tick_low_q    <= '0;
			phase_step_q  <= '0;
			dwell_count_q <= '0;
			freq_index_q  <= '0;
			active_freq_q <= '0;
		end else if (acc) begin
			tick_low_q   <= tick_nxt;
			phase_step_q <= ps_nxt;
			freq_index_q <= fi_new;
			if (step) begin
				dwell_count_q <= '0;
				active_freq_q <= freq_new;
			end else begin
				dwell_count_q <= dwell_inc[15:0];
			end
		end
	end

	// Valid bits of the stages.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			{v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8} <= '0;
		end else if (en) begin
			v_s1 <= acc;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
			v_s7 <= v_s6;
			v_s8 <= v_s7;
		end
	end

	// Datapath combinational terms, grouped by stage boundary.
	logic [17:0] prod_c;
	logic [28:0] qmul_c;
	logic [17:0] qk_c;
	logic [17:0] rem_c;
	logic [9:0]  phase_c;
	logic [9:0]  kk_c;
	logic        neg_c;
	logic [29:0] x_c;
	logic [30:0] sum_c;
	logic [30:0] back_c;
	logic [30:0] remd_c;
	logic [15:0] mag_c;

	always_comb begin
		// Phase product of the old frequency and the new step.
		prod_c = {10'd0, old_freq_s1} * {8'd0, ps_s1};
		// Quotient estimate by 1000.
		qmul_c = {11'd0, prod_s2} * 29'(RECIP_1000);
		// Remainder with a single correction.
		qk_c   = {10'd0, qest_s3} * 18'(PHASE_MOD);
		rem_c  = prod_s3 - qk_c;
		phase_c = (rem_c >= 18'(PHASE_MOD)) ? 10'(rem_c - 18'(PHASE_MOD)) : rem_c[9:0];
		// Quadrant folding onto the quarter wave.
		if (phase_s4 < 10'(QUARTER)) begin
			kk_c = phase_s4;
		end else if (phase_s4 < 10'(2 * QUARTER)) begin
			kk_c = 10'(2 * QUARTER) - phase_s4;
		end else if (phase_s4 < 10'(3 * QUARTER)) begin
			kk_c = phase_s4 - 10'(2 * QUARTER);
		end else begin
			kk_c = 10'(4 * QUARTER) - phase_s4;
		end
		neg_c = phase_s4 >= 10'(2 * QUARTER);
		// Amplitude scaling with rounding offset.
		x_c = {15'd0, amplitude} * {15'd0, entry_s5} + 30'(ROUND_HALF);
		// Quotient estimate by 32767, low by at most one.
		sum_c = {1'b0, x_s6} + {16'd0, x_s6[29:15]};
		// Correction and sign.
		back_c = {qd_s7, 15'd0} - {15'd0, qd_s7};
		remd_c = {1'b0, x_s7} - back_c;
		mag_c  = (remd_c >= 31'(AMP_FULL)) ? qd_s7 + 16'd1 : qd_s7;
	end

	// Stage payload registers.
	always_ff @(posedge clk) begin
		if (en) begin
			old_freq_s1 <= active_freq_q;
			ps_s1       <= ps_nxt;
			meta_s1     <= '{tick: tick_nxt, angle: tick.rotor_angle,
				speed: tick.measured_speed, freq: freq_new};

			prod_s2 <= prod_c;
			meta_s2 <= meta_s1;

			prod_s3 <= prod_s2;
			qest_s3 <= qmul_c[27:20];
			meta_s3 <= meta_s2;

			phase_s4 <= phase_c;
			meta_s4  <= meta_s3;

			entry_s5 <= SINE_ROM[kk_c[7:0]];
			neg_s5   <= neg_c;
			meta_s5  <= meta_s4;

			x_s6    <= x_c;
			neg_s6  <= neg_s5;
			meta_s6 <= meta_s5;

			x_s7    <= x_s6;
			qd_s7   <= sum_c[30:15];
			neg_s7  <= neg_s6;
			meta_s7 <= meta_s6;

			drive_s8 <= neg_s7 ? 16'd0 - mag_c : mag_c;
			meta_s8  <= meta_s7;
		end
	end

	assign push            = v_s8 && !q_stat.full;
	assign push_word.drive = drive_s8;
	assign push_word.meta  = meta_s8;

endmodule

/* sv/sst_queue.sv */
// Short queue of finished ticks between the front and the back.
`timescale 1ns / 1ps
`include "stepped_sine_sweep_telemetry_defines.svh"
module sst_queue (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  sst_pkg::sst_word_t  push_word,
	input  logic                pop,
	output sst_pkg::sst_qstat_t q_stat,
	output sst_pkg::sst_word_t  head_word
);
	import sst_pkg::*;

	sst_word_t          entries_q [QDEPTH];
	logic [QPTR_W-1:0]  wr_ptr_q;
	logic [QPTR_W-1:0]  rd_ptr_q;
	logic [QCNT_W-1:0]  count_q;

	// Status and head word.
	assign q_stat.full     = count_q == QCNT_W'(QDEPTH);
	assign q_stat.nonempty = count_q != '0;
	assign head_word       = entries_q[rd_ptr_q];

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// Entry storage.
	always_ff @(posedge clk) begin
		if (push) begin
			entries_q[wr_ptr_q] <= push_word;
		end
	end

	`SST_ASSERT_IMP(a_no_overflow, push, count_q != QCNT_W'(QDEPTH), "push into a full queue")
	`SST_ASSERT_IMP(a_no_underflow, pop, count_q != '0, "pop from an empty queue")
	`SST_ASSERT_NXT(a_count_up, push && !pop, count_q == $past(count_q) + 1'b1, "fill count missed a push")

endmodule

/* sv/sst_back.sv */
// Back: serializes each queued tick into an eleven-word telemetry frame.
`timescale 1ns / 1ps
`include "stepped_sine_sweep_telemetry_defines.svh"
module sst_back (
	input  logic                clk,
	input  logic                arst_n,
	input  sst_pkg::sst_qstat_t q_stat,
	input  sst_pkg::sst_word_t  head_word,
	output logic                pop,
	sst_out_if.source           telemetry
);
	import sst_pkg::*;

	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(FRAME_LEN - 1);

	logic               cur_valid_q;
	logic [IDX_W-1:0]   idx_q;
	sst_word_t          cur_q;
	logic               out_valid_q;
	logic signed [15:0] out_drive_q;
	logic [7:0]         out_byte_q;
	logic               out_last_q;

	logic       load_out;
	logic       emit;
	logic       is_last;
	logic [7:0] frame_bytes [FRAME_LEN];

	// Frame layout, most significant byte first per field.
	always_comb begin
		frame_bytes[0]  = HDR0;
		frame_bytes[1]  = HDR1;
		frame_bytes[2]  = cur_q.meta.tick[15:8];
		frame_bytes[3]  = cur_q.meta.tick[7:0];
		frame_bytes[4]  = cur_q.meta.angle[15:8];
		frame_bytes[5]  = cur_q.meta.angle[7:0];
		frame_bytes[6]  = cur_q.meta.speed[15:8];
		frame_bytes[7]  = cur_q.meta.speed[7:0];
		frame_bytes[8]  = 8'd0;
		frame_bytes[9]  = 8'd0;
		frame_bytes[10] = cur_q.meta.freq;
	end

	// The output register reloads when empty or when its word is taken.
	always_comb begin
		load_out = !out_valid_q || telemetry.ready;
		emit     = load_out && cur_valid_q;
		is_last  = idx_q == LAST_IDX;
		pop      = q_stat.nonempty && (!cur_valid_q || (emit && is_last));
	end

	// Current tick and word counter.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_valid_q <= 1'b0;
			idx_q       <= '0;
		end else if (pop) begin
			cur_valid_q <= 1'b1;
			idx_q       <= '0;
		end else if (emit && is_last) begin
			cur_valid_q <= 1'b0;
			idx_q       <= '0;
		end else if (emit) begin
			idx_q <= idx_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			cur_q <= head_word;
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= cur_valid_q;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			out_drive_q <= cur_q.drive;
			out_byte_q  <= frame_bytes[idx_q];
			out_last_q  <= is_last;
		end
	end

	assign telemetry.valid       = out_valid_q;
	assign telemetry.drive_value = out_drive_q;
	assign telemetry.frame_byte  = out_byte_q;
	assign telemetry.last_byte   = out_last_q;

	`SST_ASSERT_NXT(a_last_marked, emit && is_last, telemetry.last_byte, "final word not marked last")
	`SST_ASSERT_IMP(a_idx_idle, idx_q != '0, cur_valid_q, "word counter running with no tick")
	`SST_ASSERT_IMP(a_pop_gap, pop, !cur_valid_q || (emit && is_last), "tick replaced mid-frame")

endmodule

/* sv/stepped_sine_sweep_telemetry.sv */
// Top level of the stepped sine sweep telemetry block.
//
// The tick channel takes one word per 1 kHz tick (rotor_angle, measured_speed).
// For each tick the telemetry channel returns eleven words: the frame bytes
// 0x5A, 0xA5, tick count, angle, speed, two zero bytes and the sweep frequency,
// each with the sine drive value of that tick; last_byte marks the eleventh.
// The APB port holds dwell_ticks at address 0 and amplitude at address 4.
// The first word of a frame follows its tick through an eight-stage drive
// pipeline, the queue, the current-tick register and the output register.
// The output gives one word per cycle while the receiver takes them; each tick
// fills eleven words of the output, so this serializer sets the sustained rate.
// Ticks are taken in consecutive cycles until the four-entry queue and the
// pipeline are full. A stalled receiver holds the output word; the queue then
// fills and the tick channel drops ready. Reset clears the sweep state to zero,
// empties the pipeline and queue, and loads dwell 1000 and amplitude 32767.
`timescale 1ns / 1ps
module stepped_sine_sweep_telemetry (
	input  logic                      clk,
	input  logic                      arst_n,
	sst_in_if.sink                    tick,
	sst_out_if.source                 telemetry,
	input  logic                      psel,
	input  logic                      penable,
	input  logic                      pwrite,
	input  logic [sst_pkg::ADDR_W-1:0] paddr,
	input  logic [31:0]               pwdata,
	output logic [31:0]               prdata,
	output logic                      pready
);
	import sst_pkg::*;

	logic [15:0] dwell_ticks_q;
	logic [14:0] amplitude_q;
	logic        cfg_wr;
	logic [0:0]  reg_idx;

	sst_qstat_t q_stat;
	sst_word_t  push_word;
	sst_word_t  head_word;
	logic       push;
	logic       pop;

	// Configuration registers.
	assign pready  = 1'b1;
	assign cfg_wr  = psel && penable && pwrite;
	assign reg_idx = paddr[2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dwell_ticks_q <= DWELL_RESET;
			amplitude_q   <= AMP_RESET;
		end else if (cfg_wr) begin
			case (reg_idx)
				REG_DWELL: dwell_ticks_q <= pwdata[15:0];
				REG_AMP:   amplitude_q   <= pwdata[14:0];
				default: ;
			endcase
		end
	end

	// Register read-back.
	always_comb begin
		case (reg_idx)
			REG_DWELL: prdata = {16'd0, dwell_ticks_q};
			REG_AMP:   prdata = {17'd0, amplitude_q};
			default:   prdata = '0;
		endcase
	end

	sst_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.tick        (tick),
		.dwell_ticks (dwell_ticks_q),
		.amplitude   (amplitude_q),
		.q_stat      (q_stat),
		.push        (push),
		.push_word   (push_word)
	);

	sst_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_word (push_word),
		.pop       (pop),
		.q_stat    (q_stat),
		.head_word (head_word)
	);

	sst_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_stat    (q_stat),
		.head_word (head_word),
		.pop       (pop),
		.telemetry (telemetry)
	);

endmodule

/* test/stepped_sine_sweep_telemetry_tb.sv */
// Self-checking testbench for the stepped sine sweep telemetry block.
`timescale 1ns / 1ps
module stepped_sine_sweep_telemetry_tb;
	import sst_pkg::*;

	localparam int CLK_HALF      = 6;
	localparam int RESET_CYCLES  = 11;
	localparam int SETTLE_CYCLES = 24;
	localparam int LONG_HOLD     = 300;
	localparam int TICKS_PER_RUN = 102;
	localparam int STEPS         = 10;

	localparam logic [ADDR_W-1:0] DWELL_ADDR = {REG_DWELL, 2'b00};
	localparam logic [ADDR_W-1:0] AMP_ADDR   = {REG_AMP, 2'b00};

	// Q30 Taylor coefficients of the odd sine polynomial.
	localparam logic [63:0] TAYLOR_1 = 64'd1686629713;
	localparam logic [63:0] TAYLOR_3 = 64'd693598668;
	localparam logic [63:0] TAYLOR_5 = 64'd85569306;
	localparam logic [63:0] TAYLOR_7 = 64'd5026995;
	localparam logic [63:0] TAYLOR_9 = 64'd172272;

	localparam logic [7:0] SWEEP_HZ [STEPS] = '{
		8'd1, 8'd5, 8'd10, 8'd20, 8'd30, 8'd40, 8'd50, 8'd80, 8'd100, 8'd150
	};

	typedef enum logic [1:0] {ROW_TICK, ROW_DWELL, ROW_AMP} row_kind_t;

	// One row of the directed plan: a tick or a register write.
	typedef struct packed {
		row_kind_t   kind;
		logic [31:0] value;
		logic [15:0] angle;
		logic [15:0] speed;
		logic        drive_known;
		logic [15:0] drive;
		logic        freq_known;
		logic [7:0]  freq;
	} row_t;

	typedef struct packed {
		logic signed [15:0] drive;
		logic [7:0]         fbyte;
		logic               last;
	} tel_word_t;

	localparam int PLAN_LEN = 27;
	localparam row_t PLAN [PLAN_LEN] = '{
		// Defaults after reset: no sweep frequency yet, so the drive is zero.
		'{ROW_TICK,  32'd0,     16'h0000, 16'h0000, 1'b1, 16'd0, 1'b1, 8'd1},
		'{ROW_TICK,  32'd0,     16'hFFFF, 16'h8000, 1'b1, 16'd0, 1'b1, 8'd1},
		'{ROW_TICK,  32'd0,     16'h8000, 16'h7FFF, 1'b1, 16'd0, 1'b1, 8'd1},
		'{ROW_TICK,  32'd0,     16'h5555, 16'hAAAA, 1'b1, 16'd0, 1'b1, 8'd1},
		'{ROW_TICK,  32'd0,     16'hAAAA, 16'h5555, 1'b1, 16'd0, 1'b1, 8'd1},
		// Dwell lowered below the count: the step comes on the next tick.
		'{ROW_DWELL, 32'd3,     16'h0000, 16'h0000, 1'b0, 16'd0, 1'b0, 8'd0},
		'{ROW_TICK,  32'd0,     16'h0001, 16'hFFFF, 1'b1, 16'd0, 1'b1, 8'd5},
		'{ROW_TICK,  32'd0,     16'h1234, 16'h0001, 1'b0, 16'd0, 1'b0, 8'd0},
		'{ROW_TICK,  32'd0,     16'hFEDC, 16'h8001, 1'b0, 16'd0, 1'b0, 8'd0},
		'{ROW_TICK,  32'd0,     16'h0F0F, 16'hF0F0, 1'b0, 16'd0, 1'b0, 8'd0},
		// Shortest dwell: walk the rest of the table and wrap.
		'{ROW_DWELL, 32'd1,     16'h0000, 16'h0000, 1'b0, 16'd0, 1'b0, 8'd0},
		'{ROW_TICK,  32'd0,     16'h0000, 16'h7FFF, 1'b0, 16'd0, 1'b0, 8'd0},
		'{ROW_TICK,  32'd0,     16'hFFFF, 16'h8000, 1'b0, 16'd0, 1'b0, 8'd0},
		'{ROW_TICK,  32'd0,     16'h00FF, 16'hFF00, 1'b0, 16'd0, 1'b0, 8'd0},
		'{ROW_TICK,  32'd0,     16'hFF00, 16'h00FF, 1'b0, 16'd0, 1'b0, 8'd0},
		'{ROW_TICK,  32'd0,     16'h3C3C, 16'hC3C3, 1'b0, 16'd0, 1'b0, 8'd0},
		'{ROW_TICK,  32'd0,     16'hC3C3, 16'h3C3C, 1'b0, 16'd0, 1'b0, 8'd0},
		'{ROW_TICK,  32'd0,     16'h7FFF, 16'h0000, 1'b0, 16'd0, 1'b0, 8'd0},
		'{ROW_TICK,  32'd0,     16'h8000, 16'hFFFF, 1'b0, 16'd0, 1'b0, 8'd0},
		// Dwell of zero steps on every tick.
		'{ROW_DWELL, 32'd0,     16'h0000, 16'h0000, 1'b0, 16'd0, 1'b0, 8'd0},
		'{ROW_TICK,  32'd0,     16'h2468, 16'h1357, 1'b0, 16'd0, 1'b0, 8'd0},
		// Zero amplitude gives a zero drive at any phase.
		'{ROW_AMP,   32'd0,     16'h0000, 16'h0000, 1'b0, 16'd0, 1'b0, 8'd0},
		'{ROW_TICK,  32'd0,     16'h9999, 16'h6666, 1'b1, 16'd0, 1'b0, 8'd0},
		'{ROW_TICK,  32'd0,     16'h6666, 16'h9999, 1'b1, 16'd0, 1'b0, 8'd0},
		'{ROW_AMP,   32'd32767, 16'h0000, 16'h0000, 1'b0, 16'd0, 1'b0, 8'd0},
		'{ROW_TICK,  32'd0,     16'hABCD, 16'h4321, 1'b0, 16'd0, 1'b0, 8'd0},
		'{ROW_TICK,  32'd0,     16'h4321, 16'hABCD, 1'b0, 16'd0, 1'b0, 8'd0}
	};

	logic        clk;
	logic        arst_n;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [ADDR_W-1:0] paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	sst_in_if  tick_ch ();
	sst_out_if tel_ch ();

	stepped_sine_sweep_telemetry dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.tick      (tick_ch),
		.telemetry (tel_ch),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready)
	);

	// Sweep state and register copies of the predictor.
	logic [15:0] sw_tick      = '0;
	logic [9:0]  sw_phase     = '0;
	logic [15:0] sw_dwell_cnt = '0;
	logic [3:0]  sw_index     = '0;
	logic [7:0]  sw_freq      = '0;
	logic [15:0] cfg_dwell    = DWELL_RESET;
	logic [14:0] cfg_amp      = AMP_RESET;

	tel_word_t frame_words_due [$];
	int        errors    = 0;
	int        gap_pct   = 0;
	int        stall_pct = 0;
	logic      hold_start = 1'b0;

	initial clk = 1'b0;
	always #(CLK_HALF) clk = ~clk;

	// Q1.15 quarter-wave sample at angle (pi/2)*k/250.
	function automatic logic [14:0] quarter_sine(input int unsigned k);
		logic [63:0] z;
		logic [63:0] z2;
		logic [63:0] p;
		logic [63:0] v;
		z  = (64'(k) << 30) / 64'd250;
		z2 = (z * z) >> 30;
		p  = TAYLOR_9;
		p  = TAYLOR_7 - ((p * z2) >> 30);
		p  = TAYLOR_5 - ((p * z2) >> 30);
		p  = TAYLOR_3 - ((p * z2) >> 30);
		p  = TAYLOR_1 - ((p * z2) >> 30);
		v  = (((p * z) >> 30) * 64'd32767 + (64'd1 << 29)) >> 30;
		if (v > 64'd32767) begin
			v = 64'd32767;
		end
		return v[14:0];
	endfunction

	// Advance the sweep by one tick and queue the eleven frame words it yields.
	task automatic predict_frame(input logic [15:0] angle, input logic [15:0] speed);
		int unsigned phase;
		int unsigned quad;
		int unsigned rem;
		int unsigned mag;
		int unsigned next_cnt;
		logic [14:0] entry;
		logic [15:0] drive;
		logic [7:0]  fb [11];
		tel_word_t   w;
		sw_tick  = sw_tick + 16'd1;
		sw_phase = (sw_phase == 10'd999) ? 10'd0 : sw_phase + 10'd1;
		// The drive uses the frequency from before this tick's step.
		phase = (int'(sw_freq) * int'(sw_phase)) % 1000;
		quad  = phase / 250;
		rem   = phase % 250;
		entry = quarter_sine((quad == 0 || quad == 2) ? rem : 250 - rem);
		mag   = (int'(cfg_amp) * int'(entry) + 16383) / 32767;
		drive = (quad >= 2) ? 16'(0 - mag) : 16'(mag);
		next_cnt = int'(sw_dwell_cnt) + 1;
		if (next_cnt >= int'(cfg_dwell)) begin
			sw_dwell_cnt = '0;
			sw_index = (sw_index == 4'(STEPS - 1)) ? 4'd0 : sw_index + 4'd1;
			sw_freq = SWEEP_HZ[sw_index];
		end else begin
			sw_dwell_cnt = 16'(next_cnt);
		end
		fb = '{HDR0, HDR1, sw_tick[15:8], sw_tick[7:0], angle[15:8], angle[7:0],
			speed[15:8], speed[7:0], 8'd0, 8'd0, SWEEP_HZ[sw_index]};
		for (int k = 0; k < FRAME_LEN; k++) begin
			w.drive = drive;
			w.fbyte = fb[k];
			w.last  = (k == FRAME_LEN - 1);
			frame_words_due.push_back(w);
		end
	endtask

	// Offer one tick word, with a random gap first, and predict it once taken.
	task automatic send_tick(input logic [15:0] angle, input logic [15:0] speed);
		@(negedge clk);
		if (gap_pct != 0 && $urandom_range(99) < gap_pct) begin
			tick_ch.valid <= 1'b0;
			do @(negedge clk); while ($urandom_range(99) < gap_pct);
		end
		tick_ch.valid          <= 1'b1;
		tick_ch.rotor_angle    <= angle;
		tick_ch.measured_speed <= speed;
		do @(posedge clk); while (!tick_ch.ready);
		predict_frame(angle, speed);
	endtask

	// Stop offering ticks and let every queued frame come out.
	task automatic wait_drain();
		@(negedge clk);
		tick_ch.valid <= 1'b0;
		while (frame_words_due.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic apb_access(input logic wr, input logic [ADDR_W-1:0] addr,
		input logic [31:0] wdata, output logic [31:0] rdata);
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= wr;
		paddr   <= addr;
		pwdata  <= wdata;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		rdata = prdata;
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	// Read a register back and compare the bits it implements.
	task automatic check_reg(input logic [ADDR_W-1:0] addr, input logic [31:0] want);
		logic [31:0] got;
		logic [31:0] mask;
		apb_access(1'b0, addr, 32'd0, got);
		mask = (addr == DWELL_ADDR) ? 32'h0000_FFFF : 32'h0000_7FFF;
		if ((got & mask) != (want & mask)) begin
			$display("%0t: register at %0d read %0d, expected %0d",
				$time, addr, got & mask, want & mask);
			errors++;
		end
	endtask

	// Registers change only with the block idle.
	task automatic set_reg(input logic [ADDR_W-1:0] addr, input logic [31:0] value);
		logic [31:0] unused;
		wait_drain();
		apb_access(1'b1, addr, value, unused);
		if (addr == DWELL_ADDR) begin
			cfg_dwell = value[15:0];
		end else begin
			cfg_amp = value[14:0];
		end
		check_reg(addr, value);
	endtask

	// Receiver: random stalls, plus one long hold counted here on request.
	always @(negedge clk) begin
		static int hold_left = 0;
		if (hold_start) begin
			hold_left = LONG_HOLD;
		end
		if (hold_left > 0) begin
			hold_left--;
			tel_ch.ready <= 1'b0;
		end else begin
			tel_ch.ready <= (stall_pct == 0) || ($urandom_range(99) >= stall_pct);
		end
	end

	// Check every telemetry word taken against the oldest expected one.
	always @(posedge clk) begin
		tel_word_t want;
		if (arst_n && tel_ch.valid && tel_ch.ready) begin
			if (frame_words_due.size() == 0) begin
				$display("%0t: unexpected word drive %0d byte %h last %b", $time,
					tel_ch.drive_value, tel_ch.frame_byte, tel_ch.last_byte);
				errors++;
			end else begin
				want = frame_words_due.pop_front();
				if (tel_ch.drive_value !== want.drive) begin
					$display("%0t: drive_value expected %0d, got %0d",
						$time, want.drive, tel_ch.drive_value);
					errors++;
				end
				if (tel_ch.frame_byte !== want.fbyte) begin
					$display("%0t: frame_byte expected %h, got %h",
						$time, want.fbyte, tel_ch.frame_byte);
					errors++;
				end
				if (tel_ch.last_byte !== want.last) begin
					$display("%0t: last_byte expected %b, got %b",
						$time, want.last, tel_ch.last_byte);
					errors++;
				end
			end
		end
	end

	// Stimulus: directed plan, then four randomized runs with different idling.
	initial begin
		int base;
		arst_n  = 1'b0;
		psel    = 1'b0;
		penable = 1'b0;
		pwrite  = 1'b0;
		paddr   = '0;
		pwdata  = '0;
		tick_ch.valid          = 1'b0;
		tick_ch.rotor_angle    = '0;
		tick_ch.measured_speed = '0;
		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		check_reg(DWELL_ADDR, 32'(DWELL_RESET));
		check_reg(AMP_ADDR, 32'(AMP_RESET));

		for (int i = 0; i < PLAN_LEN; i++) begin
			case (PLAN[i].kind)
				ROW_DWELL: set_reg(DWELL_ADDR, PLAN[i].value);
				ROW_AMP: set_reg(AMP_ADDR, PLAN[i].value);
				default: begin
					send_tick(PLAN[i].angle, PLAN[i].speed);
					base = frame_words_due.size() - FRAME_LEN;
					for (int k = 0; k < FRAME_LEN; k++) begin
						if (PLAN[i].drive_known) begin
							frame_words_due[base + k].drive = PLAN[i].drive;
						end
					end
					if (PLAN[i].freq_known) begin
						frame_words_due[base + FRAME_LEN - 1].fbyte = PLAN[i].freq;
					end
				end
			endcase
		end

		for (int run = 0; run < 4; run++) begin
			case (run)
				0: begin
					set_reg(DWELL_ADDR, 32'd1);
					set_reg(AMP_ADDR, 32'd32767);
					gap_pct   <= 0;
					stall_pct <= 0;
				end
				1: begin
					set_reg(DWELL_ADDR, 32'd65535);
					set_reg(AMP_ADDR, $urandom_range(32767));
					gap_pct   <= 60;
					stall_pct <= 0;
				end
				2: begin
					set_reg(DWELL_ADDR, $urandom_range(12, 2));
					set_reg(AMP_ADDR, $urandom_range(32767));
					gap_pct   <= 0;
					stall_pct <= 60;
				end
				default: begin
					set_reg(DWELL_ADDR, $urandom_range(6, 1));
					set_reg(AMP_ADDR, $urandom_range(32767, 1));
					gap_pct   <= 29;
					stall_pct <= 29;
				end
			endcase
			for (int n = 0; n < TICKS_PER_RUN; n++) begin
				if (run == 2 && n == 30) begin
					// Long receiver hold while ticks keep coming: the input backs up.
					@(negedge clk);
					tick_ch.valid <= 1'b0;
					hold_start    <= 1'b1;
					@(negedge clk);
					hold_start <= 1'b0;
				end
				if (run == 2 && n == 70) begin
					wait_drain();
				end
				send_tick(16'($urandom), 16'($urandom));
			end
		end

		wait_drain();
		if (errors == 0) begin
			$display("stepped_sine_sweep_telemetry test passed");
		end else begin
			$display("stepped_sine_sweep_telemetry test failed");
		end
		$finish;
	end

	// Watchdog for a hung handshake.
	initial begin
		#(5_000_000);
		$display("stepped_sine_sweep_telemetry test failed");
		$finish;
	end

endmodule

/* sim.f */
+incdir+sv
sv/sst_pkg.sv
sv/sst_if.sv
sv/sst_front.sv
sv/sst_queue.sv
sv/sst_back.sv
sv/stepped_sine_sweep_telemetry.sv
test/stepped_sine_sweep_telemetry_tb.sv
